>>> sv/bcsg_pkg.sv
// Shared types, constants and codes for the beam contact surface gap block.
`timescale 1ns / 1ps
`default_nettype none

package bcsg_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = (($clog2(MAX_FRAMES + 1) > 9) ? $clog2(MAX_FRAMES + 1) : 9) + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [16:0] ONE_W = 17'd65536;

    localparam logic [1:0] CMD_WR_FIRST  = 2'd0;
    localparam logic [1:0] CMD_WR_SECOND = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    localparam logic [1:0] WP_FIRST  = 2'd0;
    localparam logic [1:0] WP_SECOND = 2'd1;
    localparam logic [1:0] WP_GAP    = 2'd2;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    localparam logic [2:0] CFG_OUTPUT_MODE     = 3'd0;
    localparam logic [2:0] CFG_NODE_TO_SEGMENT = 3'd1;
    localparam logic [2:0] CFG_RADIUS_FIRST    = 3'd2;
    localparam logic [2:0] CFG_RADIUS_SECOND   = 3'd3;
    localparam logic [2:0] CFG_MIN_DISTANCE    = 3'd4;
    localparam logic [2:0] CFG_FRAMES_FIRST    = 3'd5;
    localparam logic [2:0] CFG_FRAMES_SECOND   = 3'd6;

    typedef struct packed {
        logic        output_mode;
        logic        node_to_segment;
        logic [30:0] radius_first;
        logic [30:0] radius_second;
        logic [15:0] min_distance;
        logic [8:0]  frames_first;
        logic [8:0]  frames_second;
    } t_cfg;

    // One query as handed from the front to the back: points in order
    // first x, y, z, second x, y, z.
    typedef struct packed {
        logic            ok;
        logic [16:0]     alpha;
        logic [16:0]     beta;
        logic [5:0][31:0] p0;
        logic [5:0][31:0] p1;
        logic [63:0]     quat;
    } t_qitem;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_ERR,
        BS_LERP,
        BS_DIFF,
        BS_SQ,
        BS_SQRT,
        BS_CHECK,
        BS_FBMUL,
        BS_FBT,
        BS_DIV,
        BS_SCALE,
        BS_OUT0,
        BS_OUT1
    } t_bstate;

endpackage

`default_nettype wire

>>> sv/beam_contact_surface_gap_top.sv
// Top level of the beam contact surface gap block: configuration and module wiring.
//
// Input channel (i_valid / o_stall) carries frame writes and contact queries.
// A write item is stored in the frame tables at once; writes are accepted
// every cycle while o_stall is low. A query is range-checked and its frames
// fetched in the front end, then waits in a two-entry queue for the geometry
// engine. The engine works one query at a time through a shared multiplier,
// a square root unit and a restoring divider, and takes longer when the
// fallback normal is taken; an out-of-range query skips that work.
// Output channel (o_valid / i_stall) gives one gap result, or two surface
// point results in point mode, the final one flagged by o_last; a bad index
// gives one result with o_status set. Results sit in an output register; while
// the receiver stalls the engine holds, the queue fills and then o_stall rises.
// Reset (synchronous, active low) empties the queue and engine and loads the
// register defaults; the frame tables hold no defined value until written.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module beam_contact_surface_gap_top import bcsg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [7:0]         i_index_a,
    input  wire logic [7:0]         i_index_b,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic [16:0]        i_alpha,
    input  wire logic [16:0]        i_beta,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_status,
    output logic [1:0]              o_which_point,
    output logic signed [31:0]      o_vec_x,
    output logic signed [31:0]      o_vec_y,
    output logic signed [31:0]      o_vec_z,
    output logic                    o_last
);

    t_cfg   r_cfg, n_cfg;
    logic   push, full, pop, empty;
    t_qitem push_item, head;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OUTPUT_MODE:     n_cfg.output_mode     = i_cfg_data[0];
                CFG_NODE_TO_SEGMENT: n_cfg.node_to_segment = i_cfg_data[0];
                CFG_RADIUS_FIRST:    n_cfg.radius_first    = i_cfg_data;
                CFG_RADIUS_SECOND:   n_cfg.radius_second   = i_cfg_data;
                CFG_MIN_DISTANCE:    n_cfg.min_distance    = i_cfg_data[15:0];
                CFG_FRAMES_FIRST:    n_cfg.frames_first    = i_cfg_data[8:0];
                CFG_FRAMES_SECOND:   n_cfg.frames_second   = i_cfg_data[8:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_mode     <= 1'b0;
            r_cfg.node_to_segment <= 1'b0;
            r_cfg.radius_first    <= 31'd6554;
            r_cfg.radius_second   <= 31'd6554;
            r_cfg.min_distance    <= 16'd1;
            r_cfg.frames_first    <= 9'd0;
            r_cfg.frames_second   <= 9'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bcsg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_index_a (i_index_a),
        .i_index_b (i_index_b),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .i_alpha   (i_alpha),
        .i_beta    (i_beta),
        .o_push    (push),
        .o_item    (push_item),
        .i_full    (full)
    );

    bcsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    bcsg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_which_point (o_which_point),
        .o_vec_x       (o_vec_x),
        .o_vec_y       (o_vec_y),
        .o_vec_z       (o_vec_z),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

>>> sv/bcsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bcsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/bcsg_front.sv
// Front end: accepts requests, writes frame tables, range-checks and fetches queries.
`timescale 1ns / 1ps
`default_nettype none

module bcsg_front import bcsg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [7:0]         i_index_a,
    input  wire logic [7:0]         i_index_b,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic [16:0]        i_alpha,
    input  wire logic [16:0]        i_beta,
    output logic                    o_push,
    output t_qitem                  o_item,
    input  wire logic               i_full
);

    logic             accept;
    logic [CNT_W-1:0] ia_ext, ia1_ext, ib_ext, ib1_ext, n1, n2;
    logic             wr_in, we_first, we_second, re, ok;
    logic [159:0]     wd_first, rd_fa;
    logic [95:0]      wd_pos, rd_fb, rd_sa, rd_sb;

    logic        r_s1_valid, n_s1_valid;
    logic        r_s1_ok;
    logic [16:0] r_s1_alpha, r_s1_beta;

    assign o_stall = r_s1_valid && i_full;
    assign accept  = i_valid && !o_stall;

    assign ia_ext  = CNT_W'(i_index_a);
    assign ia1_ext = ia_ext + CNT_W'(1);
    assign ib_ext  = CNT_W'(i_index_b);
    assign ib1_ext = ib_ext + CNT_W'(1);

    // Frame counts above the table depth act as the depth.
    assign n1 = (CNT_W'(i_cfg.frames_first) > CNT_W'(MAX_FRAMES)) ?
                CNT_W'(MAX_FRAMES) : CNT_W'(i_cfg.frames_first);
    assign n2 = (CNT_W'(i_cfg.frames_second) > CNT_W'(MAX_FRAMES)) ?
                CNT_W'(MAX_FRAMES) : CNT_W'(i_cfg.frames_second);

    assign ok = (i_cfg.node_to_segment ? (ia_ext < n1) : (ia1_ext < n1)) && (ib1_ext < n2);

    assign wr_in     = ia_ext < CNT_W'(MAX_FRAMES);
    assign we_first  = accept && (i_command == CMD_WR_FIRST) && wr_in;
    assign we_second = accept && (i_command == CMD_WR_SECOND) && wr_in;
    assign re        = accept && (i_command == CMD_QUERY);

    assign wd_pos   = {i_pos_z, i_pos_y, i_pos_x};
    assign wd_first = {i_quat_w, i_quat_z, i_quat_y, i_quat_x, i_pos_z, i_pos_y, i_pos_x};

    // Each table is kept twice so that both ends of a segment are read in the same cycle.
    bcsg_ram #(.WIDTH(160), .DEPTH(MAX_FRAMES)) u_first_a (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (ia_ext[ADDR_W-1:0]),
        .i_wdata (wd_first),
        .i_re    (re),
        .i_raddr (ia_ext[ADDR_W-1:0]),
        .o_rdata (rd_fa)
    );

    bcsg_ram #(.WIDTH(96), .DEPTH(MAX_FRAMES)) u_first_b (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (ia_ext[ADDR_W-1:0]),
        .i_wdata (wd_pos),
        .i_re    (re),
        .i_raddr (ia1_ext[ADDR_W-1:0]),
        .o_rdata (rd_fb)
    );

    bcsg_ram #(.WIDTH(96), .DEPTH(MAX_FRAMES)) u_second_a (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (ia_ext[ADDR_W-1:0]),
        .i_wdata (wd_pos),
        .i_re    (re),
        .i_raddr (ib_ext[ADDR_W-1:0]),
        .o_rdata (rd_sa)
    );

    bcsg_ram #(.WIDTH(96), .DEPTH(MAX_FRAMES)) u_second_b (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (ia_ext[ADDR_W-1:0]),
        .i_wdata (wd_pos),
        .i_re    (re),
        .i_raddr (ib1_ext[ADDR_W-1:0]),
        .o_rdata (rd_sb)
    );

    assign o_push = r_s1_valid && !i_full;

    always_comb begin
        o_item       = '0;
        o_item.ok    = r_s1_ok;
        o_item.alpha = r_s1_alpha;
        o_item.beta  = r_s1_beta;
        o_item.p0    = {rd_sa, rd_fa[95:0]};
        o_item.p1    = {rd_sb, rd_fb};
        o_item.quat  = rd_fa[159:96];
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (re) begin
            n_s1_valid = 1'b1;
        end else if (o_push) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Weights above one clamp to one.
    always_ff @(posedge i_clk) begin
        if (re) begin
            r_s1_ok    <= ok;
            r_s1_alpha <= (i_alpha > ONE_W) ? ONE_W : i_alpha;
            r_s1_beta  <= (i_beta > ONE_W) ? ONE_W : i_beta;
        end
    end

endmodule

`default_nettype wire

>>> sv/bcsg_queue.sv
// Short query queue between the front end and the geometry engine.
`timescale 1ns / 1ps
`default_nettype none

module bcsg_queue import bcsg_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qitem i_item,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_qitem      o_head,
    output logic        o_empty
);

    t_qitem              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/bcsg_back.sv
// Geometry engine: interpolation, normal, fallback, surface points and result register.
`timescale 1ns / 1ps
`default_nettype none

module bcsg_back import bcsg_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cfg         i_cfg,
    input  wire t_qitem       i_head,
    input  wire logic         i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic              o_status,
    output logic [1:0]        o_which_point,
    output logic signed [31:0] o_vec_x,
    output logic signed [31:0] o_vec_y,
    output logic signed [31:0] o_vec_z,
    output logic              o_last
);

    function automatic logic [31:0] sat32(input logic signed [34:0] x);
        logic [31:0] res;
        if (x > 35'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (x < -35'sh0_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] x);
        return x[32] ? 33'(-x) : 33'(x);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    t_bstate r_state, n_state;
    logic [2:0]  r_k, n_k;
    logic        r_ph, n_ph;
    logic [4:0]  r_it, n_it;
    logic        r_fb, n_fb;
    t_qitem      r_item, n_item;
    logic signed [65:0] r_prod, n_prod;
    logic signed [31:0] r_pt [6], n_pt [6];
    logic signed [31:0] r_ds [3], n_ds [3];
    logic [1:0]  r_s, n_s;
    logic [63:0] r_acc, n_acc, r_root, n_root, r_bit, n_bit;
    logic signed [31:0] r_fq [6], n_fq [6];
    logic signed [31:0] r_n [3], n_n [3];
    logic signed [33:0] r_c [6], n_c [6];
    logic [33:0] r_rem, n_rem;
    logic [30:0] r_quo, n_quo;

    logic        r_ovalid, n_ovalid;
    logic        r_status, n_status;
    logic [1:0]  r_which, n_which;
    logic [31:0] r_vx, n_vx, r_vy, n_vy, r_vz, n_vz;
    logic        r_last, n_last;

    logic        can_load;
    logic [1:0]  ksel, kd, kd1;
    logic signed [31:0] p0s [6], p1s [6];
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [32:0] m_a, m_b, lerp_diff;
    logic signed [65:0] lerp_sum, scale_sum;
    logic signed [31:0] lerp_pt;
    logic signed [33:0] sr;
    logic signed [32:0] d [3], d1 [3];
    logic signed [31:0] ds_sel [3];
    logic        fit0, fit1;
    logic [1:0]  s_sel;
    logic [63:0] root_plus;
    logic [32:0] dn;
    logic        near;
    logic [31:0] ds_mag [3];
    logic [33:0] den, div_t;
    logic        div_ge, bit_in;
    logic [30:0] quo_nx;
    logic signed [31:0] n_val;
    logic signed [32:0] qsum_yz, t1w, t2w;
    logic signed [34:0] t0w;
    logic signed [31:0] t0, t1, t2;
    logic [31:0] m0, m1, m2, mbest;
    logic        b1, b2;
    logic signed [31:0] c_sel [3];

    assign can_load = !r_ovalid || !i_stall;
    assign ksel     = (r_k >= 3'd3) ? 2'(r_k - 3'd3) : r_k[1:0];
    assign kd       = r_k[1:0];
    assign kd1      = r_k[1:0] + 2'd1;

    assign qx = r_item.quat[15:0];
    assign qy = r_item.quat[31:16];
    assign qz = r_item.quat[47:32];
    assign qw = r_item.quat[63:48];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            p0s[i] = r_item.p0[i];
            p1s[i] = r_item.p1[i];
        end
    end

    // Interpolation as p0 + (p1 - p0) * w, rounded half up.
    assign lerp_diff = 33'(p1s[r_k]) - 33'(p0s[r_k]);
    assign lerp_sum  = (66'(p0s[r_k]) <<< 16) + r_prod + 66'sd32768;
    assign lerp_pt   = lerp_sum[47:16];

    assign scale_sum = r_prod + (66'sd1 <<< 29);
    assign sr        = scale_sum[63:30];

    // Shared multiplier operands.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            BS_LERP: begin
                m_a = lerp_diff;
                m_b = (r_k < 3'd3) ? 33'(r_item.alpha) : 33'(r_item.beta);
            end
            BS_SQ: begin
                m_a = 33'(r_ds[kd]);
                m_b = 33'(r_ds[kd]);
            end
            BS_FBMUL: begin
                case (r_k)
                    3'd0:    begin m_a = 33'(qy); m_b = 33'(qy); end
                    3'd1:    begin m_a = 33'(qz); m_b = 33'(qz); end
                    3'd2:    begin m_a = 33'(qx); m_b = 33'(qy); end
                    3'd3:    begin m_a = 33'(qz); m_b = 33'(qw); end
                    3'd4:    begin m_a = 33'(qx); m_b = 33'(qz); end
                    default: begin m_a = 33'(qy); m_b = 33'(qw); end
                endcase
            end
            BS_SCALE: begin
                m_a = 33'(r_n[ksel]);
                m_b = (r_k < 3'd3) ? 33'(r_cfg_r1()) : 33'(r_cfg_r2());
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    function automatic logic signed [32:0] r_cfg_r1();
        return $signed({2'b00, i_cfg.radius_first});
    endfunction

    function automatic logic signed [32:0] r_cfg_r2();
        return $signed({2'b00, i_cfg.radius_second});
    endfunction

    assign n_prod = m_a * m_b;

    // Pre-shift of the difference so that the squares fit 64 bits.
    always_comb begin
        fit0 = 1'b1;
        fit1 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            d[i]  = 33'(r_pt[i + 3]) - 33'(r_pt[i]);
            d1[i] = d[i] >>> 1;
            if (mag33(d[i]) >= 33'h0_8000_0000) begin
                fit0 = 1'b0;
            end
            if (mag33(d1[i]) >= 33'h0_8000_0000) begin
                fit1 = 1'b0;
            end
        end
        s_sel = fit0 ? 2'd0 : (fit1 ? 2'd1 : 2'd2);
        for (int i = 0; i < 3; i++) begin
            ds_sel[i] = fit0 ? d[i][31:0] : (fit1 ? d1[i][31:0] : 32'(d[i] >>> 2));
            ds_mag[i] = mag32(r_ds[i]);
        end
    end

    assign root_plus = r_root + r_bit;
    assign dn        = r_root[32:0];
    assign near      = (dn == '0) || ((35'(dn) << r_s) < 35'(i_cfg.min_distance));

    // Restoring divide of |num| * 2^30 by the norm, one quotient bit a cycle.
    assign den    = {1'b0, r_root[32:0]};
    assign bit_in = (r_it == 5'd0) ? ds_mag[kd][0] : 1'b0;
    assign div_t  = {r_rem[32:0], bit_in};
    assign div_ge = div_t >= den;
    assign quo_nx = {r_quo[29:0], div_ge};
    assign n_val  = r_ds[kd][31] ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});

    // Fallback: tangent from the quaternion, crossed with the least aligned axis.
    always_comb begin
        qsum_yz = 33'(r_fq[0]) + 33'(r_fq[1]);
        t0w     = 35'sd1073741824 - (35'(qsum_yz) <<< 1);
        t0      = t0w[33:2];
        t1w     = 33'(r_fq[2]) + 33'(r_fq[3]);
        t1      = t1w[32:1];
        t2w     = 33'(r_fq[4]) - 33'(r_fq[5]);
        t2      = t2w[32:1];
        m0      = mag32(t0);
        m1      = mag32(t1);
        m2      = mag32(t2);
        b1      = m1 < m0;
        mbest   = b1 ? m1 : m0;
        b2      = m2 < mbest;
        if (b2) begin
            c_sel[0] = t1;
            c_sel[1] = -t0;
            c_sel[2] = '0;
        end else if (b1) begin
            c_sel[0] = -t2;
            c_sel[1] = '0;
            c_sel[2] = t0;
        end else begin
            c_sel[0] = '0;
            c_sel[1] = t2;
            c_sel[2] = -t1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_ph     = r_ph;
        n_it     = r_it;
        n_fb     = r_fb;
        n_item   = r_item;
        n_pt     = r_pt;
        n_ds     = r_ds;
        n_s      = r_s;
        n_acc    = r_acc;
        n_root   = r_root;
        n_bit    = r_bit;
        n_fq     = r_fq;
        n_n      = r_n;
        n_c      = r_c;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_ovalid = r_ovalid && i_stall;
        n_status = r_status;
        n_which  = r_which;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_vz     = r_vz;
        n_last   = r_last;
        o_pop    = 1'b0;

        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_item  = i_head;
                    n_k     = '0;
                    n_ph    = 1'b0;
                    n_fb    = 1'b0;
                    n_state = i_head.ok ? BS_LERP : BS_ERR;
                end
            end
            BS_ERR: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_status = ST_RANGE;
                    n_which  = i_cfg.output_mode ? WP_FIRST : WP_GAP;
                    n_vx     = '0;
                    n_vy     = '0;
                    n_vz     = '0;
                    n_last   = 1'b1;
                    n_state  = BS_IDLE;
                end
            end
            BS_LERP: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_pt[r_k] = (i_cfg.node_to_segment && (r_k < 3'd3)) ? p0s[r_k] : lerp_pt;
                    if (r_k == 3'd5) begin
                        n_k     = '0;
                        n_state = BS_DIFF;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            BS_DIFF: begin
                n_ds    = ds_sel;
                n_s     = s_sel;
                n_acc   = '0;
                n_k     = '0;
                n_ph    = 1'b0;
                n_state = BS_SQ;
            end
            BS_SQ: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc = r_acc + r_prod[63:0];
                    if (r_k == 3'd2) begin
                        n_root  = '0;
                        n_bit   = 64'h4000_0000_0000_0000;
                        n_it    = '0;
                        n_state = BS_SQRT;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            BS_SQRT: begin
                if (r_acc >= root_plus) begin
                    n_acc  = r_acc - root_plus;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_it == 5'd31) begin
                    n_state = BS_CHECK;
                end else begin
                    n_it = r_it + 5'd1;
                end
            end
            BS_CHECK: begin
                n_k  = '0;
                n_ph = 1'b0;
                n_it = '0;
                if (r_fb && (dn == '0)) begin
                    // degenerate tangent: zero normal
                    for (int i = 0; i < 3; i++) begin
                        n_n[i] = '0;
                    end
                    n_state = BS_SCALE;
                end else if (!r_fb && near) begin
                    n_fb    = 1'b1;
                    n_state = BS_FBMUL;
                end else begin
                    n_rem   = {3'b000, ds_mag[0][31:1]};
                    n_quo   = '0;
                    n_state = BS_DIV;
                end
            end
            BS_FBMUL: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_fq[r_k] = r_prod[31:0];
                    if (r_k == 3'd5) begin
                        n_state = BS_FBT;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            BS_FBT: begin
                n_ds    = c_sel;
                n_acc   = '0;
                n_k     = '0;
                n_ph    = 1'b0;
                n_state = BS_SQ;
            end
            BS_DIV: begin
                n_rem = div_ge ? (div_t - den) : div_t;
                n_quo = quo_nx;
                if (r_it == 5'd30) begin
                    n_n[kd] = n_val;
                    n_it    = '0;
                    if (r_k == 3'd2) begin
                        n_k     = '0;
                        n_ph    = 1'b0;
                        n_state = BS_SCALE;
                    end else begin
                        n_k   = r_k + 3'd1;
                        n_rem = {3'b000, ds_mag[kd1][31:1]};
                        n_quo = '0;
                    end
                end else begin
                    n_it = r_it + 5'd1;
                end
            end
            BS_SCALE: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_c[r_k] = (r_k < 3'd3) ? (34'(r_pt[r_k]) + sr) : (34'(r_pt[r_k]) - sr);
                    if (r_k == 3'd5) begin
                        n_state = BS_OUT0;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            BS_OUT0: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    if (i_cfg.output_mode) begin
                        n_which = WP_FIRST;
                        n_vx    = sat32(35'(r_c[0]));
                        n_vy    = sat32(35'(r_c[1]));
                        n_vz    = sat32(35'(r_c[2]));
                        n_last  = 1'b0;
                        n_state = BS_OUT1;
                    end else begin
                        n_which = WP_GAP;
                        n_vx    = sat32(35'(r_c[3]) - 35'(r_c[0]));
                        n_vy    = sat32(35'(r_c[4]) - 35'(r_c[1]));
                        n_vz    = sat32(35'(r_c[5]) - 35'(r_c[2]));
                        n_last  = 1'b1;
                        n_state = BS_IDLE;
                    end
                end
            end
            BS_OUT1: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_which  = WP_SECOND;
                    n_vx     = sat32(35'(r_c[3]));
                    n_vy     = sat32(35'(r_c[4]));
                    n_vz     = sat32(35'(r_c[5]));
                    n_last   = 1'b1;
                    n_state  = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_k      <= '0;
            r_ph     <= 1'b0;
            r_it     <= '0;
            r_fb     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_ph     <= n_ph;
            r_it     <= n_it;
            r_fb     <= n_fb;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_prod   <= n_prod;
        r_pt     <= n_pt;
        r_ds     <= n_ds;
        r_s      <= n_s;
        r_acc    <= n_acc;
        r_root   <= n_root;
        r_bit    <= n_bit;
        r_fq     <= n_fq;
        r_n      <= n_n;
        r_c      <= n_c;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_status <= n_status;
        r_which  <= n_which;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_vz     <= n_vz;
        r_last   <= n_last;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_which_point = r_which;
    assign o_vec_x       = r_vx;
    assign o_vec_y       = r_vy;
    assign o_vec_z       = r_vz;
    assign o_last        = r_last;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the beam contact surface gap block.
`timescale 1ns / 1ps

module tb_top;
    import bcsg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 400;
    localparam longint Q30 = 64'sd1073741824;

    typedef struct {
        logic [1:0]         cmd;
        logic [7:0]         ia;
        logic [7:0]         ib;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qx, qy, qz, qw;
        logic [16:0]        al, be;
    } t_req;

    typedef struct {
        logic               status;
        logic [1:0]         which;
        logic signed [31:0] x, y, z;
        logic               last;
    } t_contact;

    typedef struct {
        bit       is_cfg;
        logic [2:0]  cidx;
        logic [30:0] cdata;
        t_req     req;
        bit       typed;
        t_contact res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [30:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_command = '0;
    logic [7:0]         i_index_a = '0;
    logic [7:0]         i_index_b = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0] i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    logic [16:0]        i_alpha = '0, i_beta = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_status;
    logic [1:0]         o_which_point;
    logic signed [31:0] o_vec_x, o_vec_y, o_vec_z;
    logic               o_last;

    beam_contact_surface_gap_top dut (.*);

    // Shadow of the block: registers and frame tables
    bit          m_mode, m_nts;
    bit [30:0]   m_rad1, m_rad2;
    bit [15:0]   m_mind;
    bit [8:0]    m_fr1, m_fr2;
    longint      f1x[256], f1y[256], f1z[256], f2x[256], f2y[256], f2z[256];
    bit [63:0]   f1q[256];
    bit          wr1[256], wr2[256];

    t_contact    pending_contacts[$];
    int          errors = 0;
    bit          quiet = 0;
    bit          hold_req = 0;
    int          seg_hi = 2;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint lerp16(longint p0, longint p1, longint w);
        return (p0 * (65536 - w) + p1 * w + 32768) >>> 16;
    endfunction

    function automatic bit [63:0] isqrt(bit [63:0] v);
        bit [63:0] r = 0;
        bit [63:0] b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic signed [31:0] sat(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint scale_radius(longint n, bit [30:0] r);
        return (n * longint'(r) + (64'sd1 << 29)) >>> 30;
    endfunction

    // Normal from the tangent crossed with the least-aligned axis
    function automatic void tangent_normal(bit [63:0] q, output longint n[3]);
        longint qx, qy, qz, qw;
        longint t[3], c[3];
        bit [63:0] s;
        int best = 0;
        qx = longint'($signed(q[15:0]));
        qy = longint'($signed(q[31:16]));
        qz = longint'($signed(q[47:32]));
        qw = longint'($signed(q[63:48]));
        t[0] = ((64'sd1 << 30) - 2 * (qy * qy + qz * qz)) >>> 2;
        t[1] = (2 * (qx * qy + qz * qw)) >>> 2;
        t[2] = (2 * (qx * qz - qy * qw)) >>> 2;
        for (int k = 1; k < 3; k++)
            if (mag(t[k]) < mag(t[best])) best = k;
        case (best)
            0: begin c[0] = 0; c[1] = t[2]; c[2] = -t[1]; end
            1: begin c[0] = -t[2]; c[1] = 0; c[2] = t[0]; end
            default: begin c[0] = t[1]; c[1] = -t[0]; c[2] = 0; end
        endcase
        s = isqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
        for (int k = 0; k < 3; k++)
            n[k] = (s != 0) ? (c[k] * Q30) / longint'(s) : 0;
    endfunction

    function automatic bit query_ok(logic [7:0] ia, logic [7:0] ib);
        int n1, n2;
        n1 = (m_fr1 > 256) ? 256 : m_fr1;
        n2 = (m_fr2 > 256) ? 256 : m_fr2;
        return (m_nts ? (ia < n1) : (ia + 1 < n1)) && (ib + 1 < n2);
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [30:0] v);
        case (idx)
            CFG_OUTPUT_MODE:     m_mode = v[0];
            CFG_NODE_TO_SEGMENT: m_nts = v[0];
            CFG_RADIUS_FIRST:    m_rad1 = v;
            CFG_RADIUS_SECOND:   m_rad2 = v;
            CFG_MIN_DISTANCE:    m_mind = v[15:0];
            CFG_FRAMES_FIRST:    m_fr1 = v[8:0];
            CFG_FRAMES_SECOND:   m_fr2 = v[8:0];
            default: ;
        endcase
    endfunction

    // Update the frame tables or compute the contact results of one request
    function automatic void contact_geometry(t_req r, output t_contact res[$]);
        longint a, b, pa[3], pb[3], d[3], ds[3], n[3], ca[3], cb[3];
        bit [63:0] dn;
        int s;
        bit fits;
        t_contact c;
        res = {};
        if (r.cmd == CMD_WR_FIRST) begin
            f1x[r.ia] = r.px; f1y[r.ia] = r.py; f1z[r.ia] = r.pz;
            f1q[r.ia] = {r.qw, r.qz, r.qy, r.qx};
            wr1[r.ia] = 1;
            return;
        end
        if (r.cmd == CMD_WR_SECOND) begin
            f2x[r.ia] = r.px; f2y[r.ia] = r.py; f2z[r.ia] = r.pz;
            wr2[r.ia] = 1;
            return;
        end
        if (r.cmd != CMD_QUERY) return;
        if (!query_ok(r.ia, r.ib)) begin
            c = '{ST_RANGE, m_mode ? WP_FIRST : WP_GAP, 0, 0, 0, 1'b1};
            res.push_back(c);
            return;
        end
        a = (r.al > 65536) ? 65536 : r.al;
        b = (r.be > 65536) ? 65536 : r.be;
        if (m_nts) begin
            pa[0] = f1x[r.ia]; pa[1] = f1y[r.ia]; pa[2] = f1z[r.ia];
        end else begin
            pa[0] = lerp16(f1x[r.ia], f1x[r.ia + 1], a);
            pa[1] = lerp16(f1y[r.ia], f1y[r.ia + 1], a);
            pa[2] = lerp16(f1z[r.ia], f1z[r.ia + 1], a);
        end
        pb[0] = lerp16(f2x[r.ib], f2x[r.ib + 1], b);
        pb[1] = lerp16(f2y[r.ib], f2y[r.ib + 1], b);
        pb[2] = lerp16(f2z[r.ib], f2z[r.ib + 1], b);
        for (int k = 0; k < 3; k++) d[k] = pb[k] - pa[k];
        // drop low bits until the squares fit
        for (s = 0; s < 3; s++) begin
            fits = 1;
            for (int k = 0; k < 3; k++) begin
                ds[k] = d[k] >>> s;
                if (mag(ds[k]) >= (64'd1 << 31)) fits = 0;
            end
            if (fits) break;
        end
        dn = isqrt(ds[0] * ds[0] + ds[1] * ds[1] + ds[2] * ds[2]);
        if (dn == 0 || (dn << s) < 64'(m_mind)) begin
            tangent_normal(f1q[r.ia], n);
        end else begin
            for (int k = 0; k < 3; k++) n[k] = (ds[k] * Q30) / longint'(dn);
        end
        for (int k = 0; k < 3; k++) begin
            ca[k] = pa[k] + scale_radius(n[k], m_rad1);
            cb[k] = pb[k] - scale_radius(n[k], m_rad2);
        end
        if (m_mode) begin
            c = '{ST_OK, WP_FIRST, sat(ca[0]), sat(ca[1]), sat(ca[2]), 1'b0};
            res.push_back(c);
            c = '{ST_OK, WP_SECOND, sat(cb[0]), sat(cb[1]), sat(cb[2]), 1'b1};
            res.push_back(c);
        end else begin
            c = '{ST_OK, WP_GAP, sat(cb[0] - ca[0]), sat(cb[1] - ca[1]),
                  sat(cb[2] - ca[2]), 1'b1};
            res.push_back(c);
        end
    endfunction

    function automatic int idle_cycles();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(t_req r, bit typed, t_contact typed_res);
        t_contact res[$];
        int gap;
        @(negedge i_clk);
        i_command <= r.cmd;
        i_index_a <= r.ia;
        i_index_b <= r.ib;
        i_pos_x <= r.px; i_pos_y <= r.py; i_pos_z <= r.pz;
        i_quat_x <= r.qx; i_quat_y <= r.qy; i_quat_z <= r.qz; i_quat_w <= r.qw;
        i_alpha <= r.al; i_beta <= r.be;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        contact_geometry(r, res);
        if (typed) pending_contacts.push_back(typed_res);
        else foreach (res[k]) pending_contacts.push_back(res[k]);
        gap = idle_cycles();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Drain every result, let the engine settle, then write a register
    task automatic write_reg(logic [2:0] idx, logic [30:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, v);
    endtask

    function automatic t_req mk_frame(logic [1:0] cmd, logic [7:0] idx,
                                      longint x, longint y, longint z,
                                      longint qx, longint qy, longint qz, longint qw);
        t_req r;
        r = '{cmd, idx, $urandom, x, y, z, qx, qy, qz, qw, $urandom, $urandom};
        return r;
    endfunction

    function automatic t_req mk_query(logic [7:0] ia, logic [7:0] ib,
                                      logic [16:0] al, logic [16:0] be);
        t_req r;
        r = '{CMD_QUERY, ia, ib, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, al, be};
        return r;
    endfunction

    function automatic longint rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return longint'($signed($urandom));
        if (r < 75) return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        return longint'($urandom_range(0, 64)) - 32;
    endfunction

    function automatic t_req rand_frame(logic [1:0] cmd, logic [7:0] idx);
        longint x, y, z;
        x = rand_coord(); y = rand_coord(); z = rand_coord();
        // often put a second-beam frame right next to the first-beam frame
        if (cmd == CMD_WR_SECOND && wr1[idx] && $urandom_range(0, 2) == 0) begin
            x = f1x[idx] + $urandom_range(0, 8) - 4;
            y = f1y[idx] + $urandom_range(0, 8) - 4;
            z = f1z[idx];
        end
        return mk_frame(cmd, idx, x, y, z, $signed(16'($urandom)),
                        $signed(16'($urandom)), $signed(16'($urandom)),
                        $signed(16'($urandom)));
    endfunction

    function automatic logic [7:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, seg_hi);
        if (r < 90) return $urandom_range(254, 255);
        return $urandom;
    endfunction

    function automatic logic [16:0] pick_weight();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 65536);
        return $urandom_range(0, 131071);
    endfunction

    // Pick a query that reads only written frames; keep errors a minority
    function automatic t_req rand_query();
        logic [7:0] ia, ib;
        forever begin
            ia = pick_index();
            ib = pick_index();
            if (!query_ok(ia, ib)) begin
                if ($urandom_range(0, 3) == 0) break;
            end else if (wr1[ia] && (m_nts || wr1[ia + 1]) && wr2[ib] && wr2[ib + 1]) begin
                break;
            end
        end
        return mk_query(ia, ib, pick_weight(), pick_weight());
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_contact e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_contacts.size() == 0) begin
                $error("unexpected result: status=%0d which_point=%0d", o_status, o_which_point);
                errors++;
            end else begin
                e = pending_contacts.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
                if (o_which_point !== e.which) begin
                    $error("which_point: expected %0d, got %0d", e.which, o_which_point);
                    errors++;
                end
                if (o_vec_x !== e.x) begin
                    $error("vec_x: expected %0d, got %0d", e.x, o_vec_x);
                    errors++;
                end
                if (o_vec_y !== e.y) begin
                    $error("vec_y: expected %0d, got %0d", e.y, o_vec_y);
                    errors++;
                end
                if (o_vec_z !== e.z) begin
                    $error("vec_z: expected %0d, got %0d", e.z, o_vec_z);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                stall_left = 1500;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) begin
                stall_left = idle_cycles();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_contact none;
        t_contact err_gap, err_point;
        int nfr;
        int r;

        none = '{ST_OK, WP_GAP, 0, 0, 0, 1'b0};
        err_gap = '{ST_RANGE, WP_GAP, 0, 0, 0, 1'b1};
        err_point = '{ST_RANGE, WP_FIRST, 0, 0, 0, 1'b1};
        m_mode = 0; m_nts = 0; m_rad1 = 6554; m_rad2 = 6554;
        m_mind = 1; m_fr1 = 0; m_fr2 = 0;

        row = '{0, 0, 0, mk_query(0, 0, 0, 0), 1, err_gap};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(8'hFF, 8'hFF, 17'h1FFFF, 17'h1FFFF), 1, err_gap};
        rows.push_back(row);
        row.typed = 0;
        row.req = mk_frame(CMD_UNUSED, 3, -1, -1, -1, -1, -1, -1, -1);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_FIRST, 0, 100 << 16, 0, 0, 0, 0, 0, 32767);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_FIRST, 1, 2147483647, -2147483648, 2147483647,
                           -32768, 32767, -32768, 32767);
        rows.push_back(row);
        // tangent vanishes for this orientation
        row.req = mk_frame(CMD_WR_FIRST, 254, 5 << 16, 7 << 16, -3 << 16, 0, 16384, 16384, 0);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_FIRST, 255, -5, 9, 1 << 20, 12000, -9000, 300, 20000);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_SECOND, 0, (100 << 16) + 32768, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_SECOND, 1, -2147483648, 2147483647, -2147483648,
                           0, 0, 0, 0);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_SECOND, 254, 5 << 16, 7 << 16, -3 << 16, 0, 0, 0, 0);
        rows.push_back(row);
        row.req = mk_frame(CMD_WR_SECOND, 255, -5, 9, 1 << 20, 0, 0, 0, 0);
        rows.push_back(row);
        row = '{1, CFG_FRAMES_FIRST, 511, row.req, 0, none};
        rows.push_back(row);
        row = '{1, CFG_FRAMES_SECOND, 256, row.req, 0, none};
        rows.push_back(row);
        row = '{1, CFG_MIN_DISTANCE, 0, row.req, 0, none};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(0, 0, 0, 0), 0, none};
        rows.push_back(row);
        row.req = mk_query(0, 0, 65536, 65536);
        rows.push_back(row);
        row.req = mk_query(0, 0, 17'h1FFFF, 17'h10001);
        rows.push_back(row);
        row.req = mk_query(0, 0, 32768, 17'h1FFFF);
        rows.push_back(row);
        row.req = mk_query(254, 254, 0, 0);
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(255, 0, 0, 0), 1, err_gap};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(0, 255, 0, 0), 1, err_gap};
        rows.push_back(row);
        row = '{1, CFG_MIN_DISTANCE, 65535, row.req, 0, none};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(0, 0, 0, 0), 0, none};
        rows.push_back(row);
        row = '{1, CFG_OUTPUT_MODE, 1, row.req, 0, none};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(255, 1, 0, 0), 1, err_point};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(0, 0, 40000, 20000), 0, none};
        rows.push_back(row);
        row = '{1, CFG_NODE_TO_SEGMENT, 1, row.req, 0, none};
        rows.push_back(row);
        row = '{1, CFG_RADIUS_FIRST, 31'h7FFFFFFF, row.req, 0, none};
        rows.push_back(row);
        row = '{1, CFG_RADIUS_SECOND, 31'h7FFFFFFF, row.req, 0, none};
        rows.push_back(row);
        row = '{0, 0, 0, mk_query(255, 0, 0, 65536), 0, none};
        rows.push_back(row);
        row.req = mk_query(254, 254, 0, 0);
        rows.push_back(row);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].is_cfg) write_reg(rows[k].cidx, rows[k].cdata);
            else send(rows[k].req, rows[k].typed, rows[k].res);
        end

        for (int ph = 0; ph < 5; ph++) begin
            quiet = (ph == 3);
            nfr = $urandom_range(3, 14);
            seg_hi = nfr;
            write_reg(CFG_OUTPUT_MODE, ph % 2);
            write_reg(CFG_NODE_TO_SEGMENT, $urandom_range(0, 3) == 0);
            case (ph)
                0: begin
                    write_reg(CFG_RADIUS_FIRST, 0);
                    write_reg(CFG_RADIUS_SECOND, 0);
                    write_reg(CFG_MIN_DISTANCE, 0);
                end
                1: begin
                    write_reg(CFG_RADIUS_FIRST, 31'h7FFFFFFF);
                    write_reg(CFG_RADIUS_SECOND, $urandom_range(0, 1 << 20));
                    write_reg(CFG_MIN_DISTANCE, 65535);
                end
                default: begin
                    write_reg(CFG_RADIUS_FIRST, $urandom_range(0, 1 << 20));
                    write_reg(CFG_RADIUS_SECOND, $urandom);
                    write_reg(CFG_MIN_DISTANCE, $urandom_range(0, 65535));
                end
            endcase
            r = $urandom_range(0, 9);
            write_reg(CFG_FRAMES_FIRST, (ph == 2) ? 9'd0 : (r < 7) ? nfr : (r < 9) ? 256 : 511);
            r = $urandom_range(0, 9);
            write_reg(CFG_FRAMES_SECOND, (r < 7) ? nfr : (r < 8) ? 1 : (r < 9) ? 256 : 511);
            for (int f = 0; f < nfr; f++) begin
                send(rand_frame(CMD_WR_FIRST, f), 0, none);
                send(rand_frame(CMD_WR_SECOND, f), 0, none);
            end
            if (ph == 1) hold_req = 1;
            for (int k = 0; k < 80; k++) begin
                r = $urandom_range(0, 99);
                if (r < 72) send(rand_query(), 0, none);
                else if (r < 82) send(rand_frame(CMD_WR_FIRST, pick_index()), 0, none);
                else if (r < 94) send(rand_frame(CMD_WR_SECOND, pick_index()), 0, none);
                else send(mk_frame(CMD_UNUSED, $urandom, $signed($urandom),
                                   $signed($urandom), $signed($urandom), 0, 0, 0, 0),
                          0, none);
            end
        end

        quiet = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_contacts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/bcsg_pkg.sv
sv/bcsg_ram.sv
sv/bcsg_front.sv
sv/bcsg_queue.sv
sv/bcsg_back.sv
sv/beam_contact_surface_gap_top.sv
tb/tb_top.sv
